// ----- sv/hsfc_pkg.sv -----
// hsfc_pkg: constants and opcodes for the binary32/binary16 converter
// no dependencies
`default_nettype none
package hsfc_pkg;
  typedef enum logic {
    OP_NARROW = 1'b0,
    OP_WIDEN  = 1'b1
  } op_e;

  localparam logic [31:0] F32_INF      = 32'h7F80_0000;
  localparam logic [31:0] F32_MAX_HALF = 32'h477F_E000;
  localparam logic [31:0] F32_MIN_HALF = 32'h3880_0000;
  localparam logic [18:0] REBIAS       = 19'h1C000;
  localparam logic [15:0] HALF_INF     = 16'h7C00;
endpackage
`default_nettype wire

// ----- sv/half_single_float_converter_core.sv -----
// half_single_float_converter_core: binary32 <-> binary16 pattern converter
// depends on hsfc_pkg
`default_nettype none
// One word enters per cycle when start_i is high; busy_o is always low, since
// the input register and the result register form a two-stage pipeline with no
// feedback. Each word is held in the input register and its result on result_o
// comes from the result register, marked by done_o for exactly one cycle: the
// receiver cannot stall. Narrowing truncates the mantissa; widening is exact.
module half_single_float_converter_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        opcode_i,
  input  wire logic [31:0] operand_i,
  output logic             done_o,
  output logic [31:0]      result_o
);
  logic        in_vld_q;
  logic        op_q;
  logic [31:0] opnd_q;
  logic        out_vld_q;
  logic [31:0] res_q;
  logic [31:0] res_d;

  logic [15:0] nar;
  logic [30:0] mag;
  logic [7:0]  e32;
  logic [23:0] m24;
  logic [7:0]  sh;
  logic [31:0] wid;
  logic [14:0] hmag;
  logic [4:0]  he;
  logic [3:0]  pos;
  logic [9:0]  hm;
  logic [9:0]  nm;

  assign busy_o = 1'b0;

  always_comb begin
    mag = opnd_q[30:0];
    e32 = mag[30:23];
    m24 = (e32 == 8'd0) ? {1'b0, mag[22:0]} : {1'b1, mag[22:0]};
    sh  = 8'd126 - ((e32 == 8'd0) ? 8'd1 : e32);
    if ({1'b0, mag} > hsfc_pkg::F32_INF) begin
      nar = {1'b0, hsfc_pkg::HALF_INF[14:10], mag[22:13]};
      if (mag[22:13] == 10'd0) nar[0] = 1'b1;
    end else if ({1'b0, mag} > hsfc_pkg::F32_MAX_HALF) begin
      nar = hsfc_pkg::HALF_INF;
    end else if ({1'b0, mag} >= hsfc_pkg::F32_MIN_HALF) begin
      nar = 16'(mag[30:13] - hsfc_pkg::REBIAS[17:0]);
    end else begin
      // sh is at least 14 here, result fits in 10 bits
      nar = (sh >= 8'd24) ? 16'd0 : 16'(m24 >> sh[4:0]);
    end
    nar[15] = opnd_q[31];
  end

  always_comb begin
    hmag = opnd_q[14:0];
    he   = hmag[14:10];
    hm   = hmag[9:0];
    pos  = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (hm[i]) pos = 4'(i);
    end
    nm = 10'(hm << (4'd10 - pos));
    if (he == 5'h1F) begin
      wid = {1'b0, 8'hFF, hm, 13'd0};
    end else if (he != 5'd0) begin
      wid = {1'b0, 8'(he) + 8'd112, hm, 13'd0};
    end else if (hm == 10'd0) begin
      wid = 32'd0;
    end else begin
      wid = {1'b0, 8'(pos) + 8'd103, nm, 13'd0};
    end
    wid[31] = opnd_q[15];
  end

  assign res_d = (op_q == hsfc_pkg::OP_WIDEN) ? wid : {16'd0, nar};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start_i;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q   <= opcode_i;
      opnd_q <= operand_i;
    end
    if (in_vld_q) res_q <= res_d;
  end

  assign done_o   = out_vld_q;
  assign result_o = res_q;

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q |=> done_o) else $error("result strobe missing");
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_vld_q)) else $error("spurious result strobe");
  a_narrow_zext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && op_q == hsfc_pkg::OP_NARROW) |=> result_o[31:16] == 16'd0)
    else $error("half result not zero-extended");
endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// testbench: self-checking bench for half_single_float_converter_core
// depends on hsfc_pkg and half_single_float_converter_core
`timescale 1ns / 100ps

module testbench;

  class conv_scoreboard;
    logic [31:0] pending_q[$];
    int errors;
    int checked;

    function logic [31:0] narrow_word(logic [31:0] x);
      logic [31:0] mag;
      logic [31:0] half;
      logic [31:0] expo;
      logic [31:0] mant;
      logic [31:0] sh;
      mag = {1'b0, x[30:0]};
      if (mag > hsfc_pkg::F32_INF) begin
        half = 32'h7C00 | ((mag >> 13) & 32'h3FF);
        if (half[9:0] == 10'd0) half[0] = 1'b1;
      end else if (mag > hsfc_pkg::F32_MAX_HALF) begin
        half = 32'h7C00;
      end else if (mag >= hsfc_pkg::F32_MIN_HALF) begin
        half = (mag >> 13) - 32'h1C000;
      end else begin
        expo = mag >> 23;
        mant = mag & 32'h7FFFFF;
        if (expo == 32'd0) expo = 32'd1;
        else mant = mant | 32'h800000;
        sh = 32'd126 - expo;
        half = (sh >= 32'd32) ? 32'd0 : (mant >> sh);
      end
      return {16'd0, x[31], half[14:0]};
    endfunction

    function logic [31:0] widen_word(logic [31:0] x);
      logic [31:0] mag;
      logic [31:0] r;
      int p;
      mag = {17'd0, x[14:0]};
      if (mag[14:10] == 5'h1F) begin
        r = hsfc_pkg::F32_INF | ((mag & 32'h3FF) << 13);
      end else if (mag[14:10] != 5'd0) begin
        r = (mag + 32'h1C000) << 13;
      end else if (mag == 32'd0) begin
        r = 32'd0;
      end else begin
        p = 9;
        while (p > 0 && mag[p] == 1'b0) p--;
        r = 32'((p + 103) << 23) | ((mag << (23 - p)) & 32'h7FFFFF);
      end
      return {x[15], 31'd0} | r;
    endfunction

    function void note_word(hsfc_pkg::op_e op, logic [31:0] operand);
      pending_q.push_back(op == hsfc_pkg::OP_WIDEN ? widen_word(operand)
                                                   : narrow_word(operand));
    endfunction

    task check_word(logic [31:0] got);
      logic [31:0] want;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
      end else begin
        want = pending_q.pop_front();
        checked++;
        if (got !== want)
          report_mismatch($sformatf("result %h, expected %h", got, want));
      end
    endtask

    task report_mismatch(string msg);
      errors++;
      if (errors <= 50) $display("mismatch: %s", msg);
    endtask
  endclass

  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        opcode_i = 1'b0;
  logic [31:0] operand_i = '0;
  logic        busy_o;
  logic        done_o;
  logic [31:0] result_o;

  conv_scoreboard sb = new();
  int idle_pct = 0;
  int sent = 0;
  int quiet_cycles = 0;

  half_single_float_converter_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .opcode_i(opcode_i), .operand_i(operand_i), .done_o(done_o), .result_o(result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sample at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_word(hsfc_pkg::op_e'(opcode_i), operand_i);
      if (done_o) sb.check_word(result_o);
      if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("simulation failed");
        $finish;
      end
    end
  end

  // one word, with random idle gaps before it
  task automatic send_word(hsfc_pkg::op_e op, logic [31:0] operand);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      opcode_i <= 1'($urandom);
      operand_i <= $urandom;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    opcode_i <= op;
    operand_i <= operand;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [31:0] random_single();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(7))
      0: v[30:23] = 8'hFF;
      1: v[30:23] = 8'h00;
      2: v[30:23] = 8'($urandom_range(8'h66, 8'h70));
      3: v[30:23] = 8'($urandom_range(8'h8D, 8'h90));
      4: v[30:0] = 31'({8'h8E, 23'h7FE000} + $urandom_range(0, 3) - 1);
      default: v[30:23] = 8'($urandom_range(8'h71, 8'h8E));
    endcase
    return v;
  endfunction

  function automatic logic [31:0] random_half();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(3))
      0: v[14:10] = 5'h1F;
      1: v[14:10] = 5'h00;
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    logic [31:0] single_cases[$];
    logic [31:0] half_cases[$];
    int phase;
    single_cases = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'h477F_E000,
                     32'h477F_E001, 32'h3880_0000, 32'h387F_FFFF, 32'h0000_0001,
                     32'h3300_0000, 32'h3380_0000, 32'h7F7F_FFFF};
    half_cases = '{32'h0000_0000, 32'hFFFF_8000, 32'h0000_0001, 32'h0000_03FF,
                   32'h0000_7C00, 32'h0000_FC00, 32'h0000_7E01, 32'hABCD_7BFF,
                   32'h0000_0400};
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (single_cases[i]) send_word(hsfc_pkg::OP_NARROW, single_cases[i]);
    foreach (half_cases[i]) send_word(hsfc_pkg::OP_WIDEN, half_cases[i]);
    drain_results();
    for (phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 0) ? 0 : (phase == 1) ? 70 : (phase == 2) ? 8 : 30;
      repeat (490) begin
        if ($urandom_range(1)) send_word(hsfc_pkg::OP_WIDEN, random_half());
        else send_word(hsfc_pkg::OP_NARROW, random_single());
      end
      drain_results();
    end
    $display("sent %0d words, checked %0d results", sent, sb.checked);
    $display("covered narrowing and widening of nan, inf, overflow, subnormal and zero");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
